/* src/mcgl_pkg.sv */
// Shared types and constants for the month calendar grid layout block.
// Holds the month tables, divider control types and sequencer states.
// No dependencies.
package mcgl_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DVD_W = 15;
	localparam int REM_W = 7;
	localparam int DAY_W = 5;
	localparam int MASK_W = 31;

	localparam logic [REM_W:0] DIV_HUNDRED = 8'd100;
	localparam logic [REM_W:0] DIV_SEVEN = 8'd7;
	// Scaled reciprocals, exact for every dividend below 2**15.
	localparam logic [DVD_W-1:0] RECIP_HUNDRED = 15'd5243;
	localparam logic [DVD_W-1:0] RECIP_SEVEN = 15'd18725;
	localparam int SHIFT_HUNDRED = 19;
	localparam int SHIFT_SEVEN = 17;
	localparam logic [REM_W-1:0] REM_LAST_OF_CENTURY = 7'd99;
	localparam logic [DAY_W-1:0] FEB_LEAP_DAYS = 5'd29;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [2:0] LAST_COLUMN = 3'd6;
	localparam logic [DVD_W-1:0] YEAR_SHIFT = 15'd400;

	typedef struct packed {
		logic start;
		logic sel_seven;
	} div_ctrl_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV100 = 4'b0010,
		S_MOD7 = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] wday_offset(input logic [MONTH_W-1:0] m);
		logic [2:0] off;
		case (m)
			4'd1, 4'd5: off = 3'd0;
			4'd2, 4'd6: off = 3'd3;
			4'd3, 4'd11: off = 3'd2;
			4'd4, 4'd7: off = 3'd5;
			4'd8: off = 3'd1;
			4'd9, 4'd12: off = 3'd4;
			4'd10: off = 3'd6;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

endpackage

/* src/mcgl_div_unit.sv */
// Shared divider by a small constant (100 or 7) using a scaled reciprocal.
// Produces a 15-bit quotient, then a 7-bit remainder, in two steps after start.
// Depends on mcgl_pkg.
module mcgl_div_unit
	import mcgl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctrl_t        ctrl,
	input  logic [DVD_W-1:0] dividend,
	output logic             done,
	output logic [DVD_W-1:0] quot,
	output logic [REM_W-1:0] rem
);

	logic [DVD_W-1:0]   dvd_q;
	logic [DVD_W-1:0]   quot_q;
	logic [REM_W-1:0]   rem_q;
	logic               busy_q;
	logic               step_q;
	logic               done_q;
	logic               sel_q;
	logic [REM_W:0]     divisor;
	logic [DVD_W-1:0]   recip;
	logic [2*DVD_W-1:0] product;
	logic [DVD_W-1:0]   quot_next;
	logic [DVD_W-1:0]   rem_next;

	assign divisor = sel_q ? DIV_SEVEN : DIV_HUNDRED;
	assign recip = sel_q ? RECIP_SEVEN : RECIP_HUNDRED;
	assign product = {{DVD_W{1'b0}}, dvd_q} * {{DVD_W{1'b0}}, recip};
	assign quot_next = sel_q ? DVD_W'(product[2*DVD_W-1:SHIFT_SEVEN])
		: DVD_W'(product[2*DVD_W-1:SHIFT_HUNDRED]);
	assign rem_next = dvd_q - quot_q * {{(DVD_W-REM_W-1){1'b0}}, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= !step_q;
				if (step_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (step_q) begin
				rem_q <= rem_next[REM_W-1:0];
			end else begin
				quot_q <= quot_next;
			end
		end else if (ctrl.start) begin
			dvd_q <= dividend;
			sel_q <= ctrl.sel_seven;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem = rem_q;

endmodule

/* src/month_calendar_grid_layout.sv */
// Top level of the month calendar grid layout block.
// Sequences the weekday computation on the shared divider and emits day cells.
// Depends on mcgl_pkg and mcgl_div_unit.

// One input word names a month and a Gregorian year; the block answers with one output
// word per day of that month, day 1 first, tlast on the final day. The weekday of the
// first is found on a single shared divide-by-constant unit that multiplies by a scaled
// reciprocal: it first divides the shifted year by 100, then reduces the weekday sum
// modulo 7, and only then is the first day loaded for output. Days then leave at one
// per cycle while the output is taken, and the next input word can be accepted only
// once the last day of the month has been loaded. The input is not ready while a month
// is in progress. A month number of 0 or above 12 produces no output.
module month_calendar_grid_layout
	import mcgl_pkg::*;
#(
	parameter int CELL_WIDTH = 9,
	parameter int CELL_HEIGHT = 4,
	parameter int HEADER_HEIGHT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // month_number[3:0], year_number[17:4], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	// day_of_month[4:0], grid_column[7:5], grid_row[10:8], pixel_x[16:11],
	// pixel_y[21:17], has_activity[22], zero pad[23]
	output logic [23:0] m_tdata,
	output logic        m_tlast,   // last_cell
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);

	localparam logic [5:0] PX_BASE = 6'((CELL_WIDTH - 3) / 2);
	localparam logic [5:0] PX_STEP = 6'(CELL_WIDTH);
	localparam logic [4:0] PY_BASE = 5'(HEADER_HEIGHT + (CELL_HEIGHT - 3) / 2);
	localparam logic [4:0] PY_STEP = 5'(CELL_HEIGHT);

	state_t             state_q;
	logic [MASK_W-1:0]  mask_q;
	logic [MONTH_W-1:0] month_q;
	logic [DVD_W-1:0]   yy_q;
	logic [DAY_W-1:0]   ndays_q;
	logic [DAY_W-1:0]   day_q;
	logic [2:0]         col_q;
	logic [2:0]         row_q;
	logic [5:0]         px_q;
	logic [4:0]         py_q;
	logic               out_valid_q;
	logic [22:0]        out_data_q;
	logic               out_last_q;

	div_ctrl_t          div_ctrl;
	logic [DVD_W-1:0]   div_dividend;
	logic               div_done;
	logic [DVD_W-1:0]   div_quot;
	logic [REM_W-1:0]   div_rem;

	logic               in_fire;
	logic [MONTH_W-1:0] in_month;
	logic [YEAR_W-1:0]  in_year;
	logic               month_ok;
	logic [DVD_W-1:0]   in_yy;
	logic               leap;
	logic [15:0]        wday_sum;
	logic [2:0]         first_col;
	logic               emit_load;
	logic               is_last;

	assign in_month = s_tdata[3:0];
	assign in_year = s_tdata[17:4];
	assign s_tready = state_q == S_IDLE;
	assign in_fire = s_tvalid && s_tready;
	assign month_ok = (in_month != '0) && (in_month <= MONTH_DEC);
	assign in_yy = DVD_W'(in_year) + YEAR_SHIFT - ((in_month < MONTH_MAR) ? 15'd1 : 15'd0);

	// The year was shifted back by one for January and February, so the original year is yy + 1.
	assign leap = ((yy_q[1:0] == 2'b11) && (div_rem != REM_LAST_OF_CENTURY))
		|| ((div_rem == REM_LAST_OF_CENTURY) && (div_quot[1:0] == 2'b11));

	assign wday_sum = 16'(yy_q) + 16'(yy_q >> 2) - 16'(div_quot) + 16'(div_quot >> 2)
		+ 16'(wday_offset(month_q)) + 16'd1;

	assign first_col = div_rem[2:0];

	always_comb begin
		div_ctrl.start = 1'b0;
		div_ctrl.sel_seven = 1'b0;
		div_dividend = in_yy;
		case (state_q)
			S_IDLE: begin
				div_ctrl.start = in_fire && month_ok;
			end
			S_DIV100: begin
				div_ctrl.start = div_done;
				div_ctrl.sel_seven = 1'b1;
				div_dividend = wday_sum[DVD_W-1:0];
			end
			default: begin
				div_ctrl.start = 1'b0;
			end
		endcase
	end

	mcgl_div_unit u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || m_tready);
	assign is_last = day_q == ndays_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mask_q <= cfg_data;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && month_ok) begin
						state_q <= S_DIV100;
					end
				end
				S_DIV100: begin
					if (div_done) begin
						state_q <= S_MOD7;
					end
				end
				S_MOD7: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_load && is_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			month_q <= in_month;
			yy_q <= in_yy;
		end
		if (state_q == S_DIV100 && div_done) begin
			ndays_q <= ((month_q == MONTH_FEB) && leap) ? FEB_LEAP_DAYS : month_len(month_q);
		end
		if (state_q == S_MOD7 && div_done) begin
			day_q <= 5'd1;
			col_q <= first_col;
			row_q <= '0;
			px_q <= 6'(6'(first_col) * PX_STEP) + PX_BASE;
			py_q <= PY_BASE;
		end else if (emit_load) begin
			out_data_q <= {mask_q[day_q - 5'd1], py_q, px_q, row_q, col_q, day_q};
			out_last_q <= is_last;
			day_q <= day_q + 5'd1;
			if (col_q == LAST_COLUMN) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
				px_q <= PX_BASE;
				py_q <= py_q + PY_STEP;
			end else begin
				col_q <= col_q + 3'd1;
				px_q <= px_q + PX_STEP;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_data_q};
	assign m_tlast = out_last_q;
	assign cfg_ready = 1'b1;

endmodule
